[rtl/wsfp_pkg.sv]
// Package with the shared types of the WebSocket frame parser.
package wsfp_pkg;

   // Parse phases of the frame header and payload.
   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXT     = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   // Length codes of the 7-bit length field.
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // Extended length and mask key byte counts, minus one.
   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] KEY_LAST   = 3'd3;

   // One result word.
   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       first_of_frame;
      logic       last_of_frame;
      logic       empty_frame;
   } result_type;

endpackage

[rtl/wsfp_parse.sv]
// Frame parsing state and result generation for one received byte.
module wsfp_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   output logic                 res_valid,
   output wsfp_pkg::result_type res
);
   import wsfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  ext_cnt_ff, ext_cnt_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_en_ff, mask_en_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  idx_ff, idx_in;
   logic        started_ff, started_in;

   logic [6:0]  len7;
   logic [63:0] ext_remain;
   logic        remain_zero;
   logic        ext_remain_zero;
   logic [7:0]  key_byte;

   // Shared terms of the header fields.
   assign len7            = in_byte[6:0];
   assign ext_remain      = {remain_ff[55:0], in_byte};
   assign remain_zero     = (remain_ff == 64'd0);
   assign ext_remain_zero = (ext_remain == 64'd0);

   // Next state of the parser.
   always_comb begin
      phase_in   = phase_ff;
      ext_cnt_in = ext_cnt_ff;
      opcode_in  = opcode_ff;
      mask_en_in = mask_en_ff;
      remain_in  = remain_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      started_in = started_ff;
      case (phase_ff)
         PH_HDR1: begin
            mask_en_in = in_byte[7];
            remain_in  = 64'd0;
            if (len7 == LEN_EXT16) begin
               ext_cnt_in = EXT16_LAST;
               phase_in   = PH_EXT;
            end else if (len7 == LEN_EXT64) begin
               ext_cnt_in = EXT64_LAST;
               phase_in   = PH_EXT;
            end else begin
               // Length is known: set up for the mask key or the payload.
               remain_in  = {57'd0, len7};
               idx_in     = 2'd0;
               started_in = 1'b0;
               key_in     = 32'd0;
               if (in_byte[7]) begin
                  ext_cnt_in = KEY_LAST;
                  phase_in   = PH_MASK;
               end else begin
                  phase_in = (len7 == 7'd0) ? PH_HDR0 : PH_PAYLOAD;
               end
            end
         end
         PH_EXT: begin
            remain_in = ext_remain;
            if (ext_cnt_ff != 3'd0) begin
               ext_cnt_in = ext_cnt_ff - 3'd1;
            end else begin
               idx_in     = 2'd0;
               started_in = 1'b0;
               key_in     = 32'd0;
               if (mask_en_ff) begin
                  ext_cnt_in = KEY_LAST;
                  phase_in   = PH_MASK;
               end else begin
                  phase_in = ext_remain_zero ? PH_HDR0 : PH_PAYLOAD;
               end
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], in_byte};
            if (ext_cnt_ff != 3'd0) begin
               ext_cnt_in = ext_cnt_ff - 3'd1;
            end else begin
               phase_in = remain_zero ? PH_HDR0 : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            idx_in     = idx_ff + 2'd1;
            started_in = 1'b1;
            if (!remain_zero) begin
               remain_in = remain_ff - 64'd1;
            end
            if (remain_ff <= 64'd1) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            opcode_in = in_byte[3:0];
            phase_in  = PH_HDR1;
         end
      endcase
   end

   // Mask key byte for the current payload index; the first key byte is on top.
   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Result of the current byte: a payload word or the empty-frame marker.
   always_comb begin
      res_valid          = 1'b0;
      res.payload_byte   = 8'd0;
      res.frame_opcode   = opcode_ff;
      res.first_of_frame = 1'b1;
      res.last_of_frame  = 1'b1;
      res.empty_frame    = 1'b1;
      case (phase_ff)
         PH_HDR1: begin
            res_valid = !in_byte[7] && (len7 == 7'd0);
         end
         PH_EXT: begin
            res_valid = (ext_cnt_ff == 3'd0) && !mask_en_ff && ext_remain_zero;
         end
         PH_MASK: begin
            res_valid = (ext_cnt_ff == 3'd0) && remain_zero;
         end
         PH_PAYLOAD: begin
            res_valid          = 1'b1;
            res.payload_byte   = mask_en_ff ? (in_byte ^ key_byte) : in_byte;
            res.first_of_frame = !started_ff;
            res.last_of_frame  = (remain_ff <= 64'd1);
            res.empty_frame    = 1'b0;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // State registers, updated on each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         ext_cnt_ff <= 3'd0;
         opcode_ff  <= 4'd0;
         mask_en_ff <= 1'b0;
         remain_ff  <= 64'd0;
         key_ff     <= 32'd0;
         idx_ff     <= 2'd0;
         started_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         ext_cnt_ff <= ext_cnt_in;
         opcode_ff  <= opcode_in;
         mask_en_ff <= mask_en_in;
         remain_ff  <= remain_in;
         key_ff     <= key_in;
         idx_ff     <= idx_in;
         started_ff <= started_in;
      end
   end

endmodule

[rtl/websocket_frame_parser_core.sv]
// Top level of the WebSocket frame parser: byte input, parser and result buffering.
//
// Takes one received byte per word on the req_ channel and returns unmasked payload
// bytes on the rsp_ channel, one byte per clock while the output is not stalled, with
// marks for the first and last byte of each frame and a single empty marker for a
// zero-length frame. Header bytes produce no other word. A result leaves the parser in
// the same cycle its byte is taken and sits in an output register; a second register
// catches one more result while the output is stalled, so req_ready drops only when
// both are full. Throughput is one byte per clock while the output is not stalled.
module websocket_frame_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_first_of_frame,
   output logic       rsp_last_of_frame,
   output logic       rsp_empty_frame
);
   import wsfp_pkg::*;

   logic       accept;
   logic       pop;
   logic       gen_valid;
   result_type gen;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   // Handshakes.
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   wsfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .res_valid (gen_valid),
      .res       (gen)
   );

   // Output and skid register steering.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = accept && gen_valid;
         out_in       = gen;
      end else if (accept && gen_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = gen;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_frame_opcode   = out_ff.frame_opcode;
   assign rsp_first_of_frame = out_ff.first_of_frame;
   assign rsp_last_of_frame  = out_ff.last_of_frame;
   assign rsp_empty_frame    = out_ff.empty_frame;

endmodule

[tb/websocket_frame_checker.sv]
// Checker for the WebSocket frame parser: predicts every result word from the accepted bytes.
`timescale 1ns / 100ps

module websocket_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_payload_byte,
   input  logic [3:0]  rsp_frame_opcode,
   input  logic        rsp_first_of_frame,
   input  logic        rsp_last_of_frame,
   input  logic        rsp_empty_frame,
   output int          fail_count,
   output int          pending_count,
   output int          words_checked
);
   import wsfp_pkg::*;

   // Deframer state, kept in step with every accepted byte.
   phase_type   phase;
   logic [2:0]  bytes_left;
   logic [3:0]  opcode;
   logic        masked;
   logic [63:0] remaining;
   logic [31:0] key;
   logic [1:0]  key_idx;
   logic        started;

   // Result words predicted but not yet seen on the output.
   result_type  expected_words[$];

   // The header is complete: a zero-length frame yields its empty marker now.
   task automatic close_header(output logic produced, output result_type word);
      produced = 1'b0;
      word     = '0;
      if (remaining == 64'd0) begin
         phase    = PH_HDR0;
         produced = 1'b1;
         word     = '{payload_byte: 8'h00, frame_opcode: opcode, first_of_frame: 1'b1,
                      last_of_frame: 1'b1, empty_frame: 1'b1};
      end else begin
         phase = PH_PAYLOAD;
      end
   endtask

   // The payload length is known: go on to the mask key or finish the header.
   task automatic close_length(output logic produced, output result_type word);
      produced = 1'b0;
      word     = '0;
      key_idx  = 2'd0;
      started  = 1'b0;
      key      = 32'd0;
      if (masked) begin
         bytes_left = KEY_LAST;
         phase      = PH_MASK;
      end else begin
         close_header(produced, word);
      end
   endtask

   // Advance the deframer by one received byte.
   task automatic deframe_byte(input logic [7:0] b, output logic produced,
                               output result_type word);
      logic [7:0] data;
      logic       is_first;
      logic       is_last;
      produced = 1'b0;
      word     = '0;
      case (phase)
         PH_HDR1: begin
            masked    = b[7];
            remaining = 64'd0;
            if (b[6:0] == LEN_EXT16) begin
               bytes_left = EXT16_LAST;
               phase      = PH_EXT;
            end else if (b[6:0] == LEN_EXT64) begin
               bytes_left = EXT64_LAST;
               phase      = PH_EXT;
            end else begin
               remaining = {57'd0, b[6:0]};
               close_length(produced, word);
            end
         end
         PH_EXT: begin
            remaining = {remaining[55:0], b};
            if (bytes_left != 3'd0) begin
               bytes_left = bytes_left - 3'd1;
            end else begin
               close_length(produced, word);
            end
         end
         PH_MASK: begin
            key = {key[23:0], b};
            if (bytes_left != 3'd0) begin
               bytes_left = bytes_left - 3'd1;
            end else begin
               close_header(produced, word);
            end
         end
         PH_PAYLOAD: begin
            data     = b;
            is_first = !started;
            is_last  = (remaining <= 64'd1);
            if (masked) begin
               data = data ^ key[8 * (3 - key_idx) +: 8];
            end
            key_idx = key_idx + 2'd1;
            started = 1'b1;
            if (remaining != 64'd0) begin
               remaining = remaining - 64'd1;
            end
            if (is_last) begin
               phase = PH_HDR0;
            end
            produced = 1'b1;
            word     = '{payload_byte: data, frame_opcode: opcode, first_of_frame: is_first,
                         last_of_frame: is_last, empty_frame: 1'b0};
         end
         default: begin
            opcode = b[3:0];
            phase  = PH_HDR1;
         end
      endcase
   endtask

   // Watch both channels: compare each result word, then predict from the new byte.
   always @(posedge clock) begin : watch
      result_type predicted;
      result_type seen;
      logic       produced;
      if (reset) begin
         phase      = PH_HDR0;
         bytes_left = 3'd0;
         opcode     = 4'd0;
         masked     = 1'b0;
         remaining  = 64'd0;
         key        = 32'd0;
         key_idx    = 2'd0;
         started    = 1'b0;
         expected_words.delete();
         fail_count    <= 0;
         pending_count <= 0;
         words_checked <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("result word with no expectation: payload_byte %02h opcode %0h",
                      rsp_payload_byte, rsp_frame_opcode);
               fail_count <= fail_count + 1;
            end else begin
               predicted = expected_words.pop_front();
               seen = '{payload_byte: rsp_payload_byte, frame_opcode: rsp_frame_opcode,
                        first_of_frame: rsp_first_of_frame,
                        last_of_frame: rsp_last_of_frame, empty_frame: rsp_empty_frame};
               if (seen != predicted) begin
                  fail_count <= fail_count + 1;
                  if (seen.payload_byte != predicted.payload_byte)
                     $error("payload_byte: expected %02h, actual %02h",
                            predicted.payload_byte, seen.payload_byte);
                  if (seen.frame_opcode != predicted.frame_opcode)
                     $error("frame_opcode: expected %0h, actual %0h",
                            predicted.frame_opcode, seen.frame_opcode);
                  if (seen.first_of_frame != predicted.first_of_frame)
                     $error("first_of_frame: expected %0b, actual %0b",
                            predicted.first_of_frame, seen.first_of_frame);
                  if (seen.last_of_frame != predicted.last_of_frame)
                     $error("last_of_frame: expected %0b, actual %0b",
                            predicted.last_of_frame, seen.last_of_frame);
                  if (seen.empty_frame != predicted.empty_frame)
                     $error("empty_frame: expected %0b, actual %0b",
                            predicted.empty_frame, seen.empty_frame);
               end
               words_checked <= words_checked + 1;
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_in_byte, produced, predicted);
            if (produced) begin
               expected_words = {expected_words, predicted};
            end
         end
         pending_count <= expected_words.size();
      end
   end

endmodule

[tb/tb_websocket_frame_parser_core.sv]
// Testbench top for the WebSocket frame parser: byte stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_websocket_frame_parser_core;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 600;
   localparam int QUIET_FROM     = 500;

   typedef enum logic [1:0] {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_first_of_frame;
   logic       rsp_last_of_frame;
   logic       rsp_empty_frame;

   int fail_count;
   int pending_count;
   int words_checked;
   int bytes_sent    = 0;
   int frames_sent   = 0;
   int idle_cycles   = 0;
   bit idle_enable   = 1'b1;

   websocket_frame_parser_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_first_of_frame (rsp_first_of_frame),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_empty_frame    (rsp_empty_frame)
   );

   websocket_frame_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_first_of_frame (rsp_first_of_frame),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_empty_frame    (rsp_empty_frame),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .words_checked      (words_checked)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: the run ends if neither channel moves a word for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", idle_cycles);
         $display("** websocket_frame_parser_core: FAILED **");
         $finish;
      end
   end

   // Result side: stall in random bursts while idling is enabled.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 11)) @(posedge clock);
      end
   end

   // Present one byte, possibly after a random gap, and hold it until it is taken.
   task automatic send_byte(input logic [7:0] b);
      idle_enable = (bytes_sent < 250 || bytes_sent >= 320) && bytes_sent < QUIET_FROM;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Send a whole frame: header, optional mask key and the given number of payload bytes.
   task automatic send_frame(input logic [7:0] head0, input logic masked,
                             input len_form_type form, input logic [63:0] len,
                             input int payload_count);
      send_byte(head0);
      case (form)
         FORM_SHORT: send_byte({masked, len[6:0]});
         FORM_EXT16: begin
            send_byte({masked, 7'd126});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({masked, 7'd127});
            for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
         end
      endcase
      if (masked) begin
         repeat (4) send_byte(8'($urandom));
      end
      repeat (payload_count) send_byte(8'($urandom));
      frames_sent++;
   endtask

   // Stimulus: directed frames, random frames, then an oversized frame left open.
   initial begin : stimulus
      len_form_type form;
      logic [63:0]  len;
      logic [63:0]  huge;
      int           pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Zero-length frames ending on each kind of header byte.
      send_frame(8'h80, 1'b0, FORM_SHORT, 64'd0, 0);
      send_frame(8'hFF, 1'b1, FORM_SHORT, 64'd0, 0);
      send_frame(8'h01, 1'b0, FORM_EXT16, 64'd0, 0);
      // Unmasked single-byte frame carrying an all-ones byte.
      send_byte(8'h02);
      send_byte(8'h01);
      send_byte(8'hFF);
      // Masked two-byte frame with field extremes in key and payload.
      send_byte(8'h89);
      send_byte(8'h82);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      frames_sent += 2;

      // Random frames, mostly short, with non-minimal extended lengths mixed in.
      while (bytes_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         form = (pick < 70) ? FORM_SHORT : (pick < 85) ? FORM_EXT16 : FORM_EXT64;
         len  = 64'($urandom_range(0, 12));
         if ($urandom_range(0, 19) == 0) begin
            case (form)
               FORM_SHORT: len = 64'($urandom_range(100, 125));
               FORM_EXT16: len = 64'($urandom_range(126, 300));
               default:    len = 64'($urandom_range(13, 40));
            endcase
         end
         send_frame(8'($urandom), 1'($urandom), form, len, int'(len));
      end

      // A 64-bit length with its top bit set: only its first bytes are sent.
      huge     = {$urandom, $urandom};
      huge[63] = 1'b1;
      send_frame(8'($urandom), 1'b1, FORM_EXT64, huge, 20);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (pending_count != 0) begin
         $error("%0d predicted result words never arrived", pending_count);
      end
      $display("Sent %0d bytes in %0d frames (masked and unmasked, 7-bit, 16-bit and 64-bit",
               bytes_sent, frames_sent);
      $display("lengths, zero-length and oversized frames); %0d result words were checked.",
               words_checked);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** websocket_frame_parser_core: PASSED **");
      end else begin
         $display("** websocket_frame_parser_core: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
rtl/wsfp_pkg.sv
rtl/wsfp_parse.sv
rtl/websocket_frame_parser_core.sv
tb/websocket_frame_checker.sv
tb/tb_websocket_frame_parser_core.sv
